// ----- rtl/sm83_pkg.sv -----
// Shared types and constants for the SM83 ALU: operation codes, flag layout
// and the word structures passed between the register stages and the datapath.
// No dependencies.
`default_nettype none

package sm83_pkg;

  typedef enum logic [4:0] {
    OP_ADD    = 5'd0,
    OP_ADC    = 5'd1,
    OP_SUB    = 5'd2,
    OP_SBC    = 5'd3,
    OP_CP     = 5'd4,
    OP_AND    = 5'd5,
    OP_OR     = 5'd6,
    OP_XOR    = 5'd7,
    OP_ADD_HL = 5'd8,
    OP_ADD_SP = 5'd9,
    OP_INC16  = 5'd10,
    OP_DEC16  = 5'd11,
    OP_SWAP   = 5'd12,
    OP_INC    = 5'd13,
    OP_DEC    = 5'd14,
    OP_DAA    = 5'd15,
    OP_CPL    = 5'd16,
    OP_CCF    = 5'd17,
    OP_SCF    = 5'd18,
    OP_RLC    = 5'd19,
    OP_RL     = 5'd20,
    OP_RRC    = 5'd21,
    OP_RR     = 5'd22,
    OP_SLA    = 5'd23,
    OP_SRA    = 5'd24,
    OP_SRL    = 5'd25,
    OP_BIT    = 5'd26,
    OP_SET    = 5'd27,
    OP_RES    = 5'd28
  } op_e;

  // Flag register layout: bit 3 Z, bit 2 N, bit 1 H, bit 0 C.
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  localparam logic [7:0] DAA_LIMIT   = 8'h99;
  localparam logic [7:0] DAA_ADJ_LO  = 8'h06;
  localparam logic [7:0] DAA_ADJ_HI  = 8'h60;
  localparam logic [3:0] BCD_MAX     = 4'd9;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] operand;
    logic [15:0] base_word;
    logic [2:0]  bit_index;
    logic        shift_in;
  } item_t;

  typedef struct packed {
    logic [7:0]  acc;
    flags_t      flags;
    logic [7:0]  byte_res;
    logic [15:0] word_res;
    logic        msb_out;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/sm83_exec.sv -----
// Combinational datapath of the SM83 ALU: one operation on the current
// accumulator and flags. Depends on sm83_pkg.
`default_nettype none

module sm83_exec (
  input  sm83_pkg::item_t   item_i,
  input  logic [7:0]        acc_i,
  input  sm83_pkg::flags_t  flags_i,
  output sm83_pkg::result_t res_o
);

  logic [7:0]  v;
  logic        c;
  logic [8:0]  add_sum;
  logic [4:0]  add_half;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_half;
  logic        cin_arith;
  logic [16:0] hl_sum;
  logic [12:0] hl_half;
  logic [8:0]  sp_low;
  logic [4:0]  sp_half;
  logic [15:0] sp_sum;
  logic        daa_lo;
  logic        daa_hi;
  logic [7:0]  daa_adj;
  logic [7:0]  daa_res;
  logic [7:0]  bit_mask;
  logic [7:0]  byte_r;
  logic [7:0]  acc_r;

  assign v = item_i.operand[7:0];
  assign c = flags_i.c;

  // Carry in of the 8-bit adder and subtractor: only ADC and SBC use C.
  assign cin_arith = ((sm83_pkg::op_e'(item_i.kind) == sm83_pkg::OP_ADC) ||
                      (sm83_pkg::op_e'(item_i.kind) == sm83_pkg::OP_SBC)) ? c : 1'b0;

  assign add_sum  = {1'b0, acc_i} + {1'b0, v} + {8'd0, cin_arith};
  assign add_half = {1'b0, acc_i[3:0]} + {1'b0, v[3:0]} + {4'd0, cin_arith};
  // Bit 8 and bit 4 of the differences are the borrows.
  assign sub_diff = {1'b0, acc_i} - {1'b0, v} - {8'd0, cin_arith};
  assign sub_half = {1'b0, acc_i[3:0]} - {1'b0, v[3:0]} - {4'd0, cin_arith};

  assign hl_sum  = {1'b0, item_i.base_word} + {1'b0, item_i.operand};
  assign hl_half = {1'b0, item_i.base_word[11:0]} + {1'b0, item_i.operand[11:0]};

  assign sp_low  = {1'b0, item_i.base_word[7:0]} + {1'b0, v};
  assign sp_half = {1'b0, item_i.base_word[3:0]} + {1'b0, v[3:0]};
  assign sp_sum  = item_i.base_word + {{8{v[7]}}, v};

  assign daa_lo  = flags_i.n ? flags_i.h : (flags_i.h || (acc_i[3:0] > sm83_pkg::BCD_MAX));
  assign daa_hi  = flags_i.n ? c : (c || (acc_i > sm83_pkg::DAA_LIMIT));
  assign daa_adj = (daa_lo ? sm83_pkg::DAA_ADJ_LO : 8'd0) |
                   (daa_hi ? sm83_pkg::DAA_ADJ_HI : 8'd0);
  assign daa_res = flags_i.n ? (acc_i - daa_adj) : (acc_i + daa_adj);

  assign bit_mask = 8'h01 << item_i.bit_index;

  always_comb begin
    res_o           = '0;
    res_o.acc       = acc_i;
    res_o.flags     = flags_i;
    byte_r          = '0;
    acc_r           = '0;
    unique case (sm83_pkg::op_e'(item_i.kind))
      sm83_pkg::OP_ADD, sm83_pkg::OP_ADC: begin
        res_o.acc   = add_sum[7:0];
        res_o.flags = '{z: (add_sum[7:0] == 8'd0), n: 1'b0, h: add_half[4], c: add_sum[8]};
      end
      sm83_pkg::OP_SUB, sm83_pkg::OP_SBC, sm83_pkg::OP_CP: begin
        if (sm83_pkg::op_e'(item_i.kind) != sm83_pkg::OP_CP) begin
          res_o.acc = sub_diff[7:0];
        end
        res_o.flags = '{z: (sub_diff[7:0] == 8'd0), n: 1'b1, h: sub_half[4],
                        c: sub_diff[8]};
      end
      sm83_pkg::OP_AND: begin
        acc_r       = acc_i & v;
        res_o.acc   = acc_r;
        res_o.flags = '{z: (acc_r == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      sm83_pkg::OP_OR: begin
        acc_r       = acc_i | v;
        res_o.acc   = acc_r;
        res_o.flags = '{z: (acc_r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      sm83_pkg::OP_XOR: begin
        acc_r       = acc_i ^ v;
        res_o.acc   = acc_r;
        res_o.flags = '{z: (acc_r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      sm83_pkg::OP_ADD_HL: begin
        res_o.word_res = hl_sum[15:0];
        res_o.flags    = '{z: flags_i.z, n: 1'b0, h: hl_half[12], c: hl_sum[16]};
      end
      sm83_pkg::OP_ADD_SP: begin
        res_o.word_res = sp_sum;
        res_o.flags    = '{z: 1'b0, n: 1'b0, h: sp_half[4], c: sp_low[8]};
      end
      sm83_pkg::OP_INC16: res_o.word_res = item_i.base_word + 16'd1;
      sm83_pkg::OP_DEC16: res_o.word_res = item_i.base_word - 16'd1;
      sm83_pkg::OP_SWAP: begin
        byte_r         = {v[3:0], v[7:4]};
        res_o.byte_res = byte_r;
        res_o.flags    = '{z: (byte_r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      sm83_pkg::OP_INC: begin
        byte_r         = v + 8'd1;
        res_o.byte_res = byte_r;
        res_o.flags    = '{z: (byte_r == 8'd0), n: 1'b0, h: (v[3:0] == 4'hF), c: c};
      end
      sm83_pkg::OP_DEC: begin
        byte_r         = v - 8'd1;
        res_o.byte_res = byte_r;
        res_o.flags    = '{z: (byte_r == 8'd0), n: 1'b1, h: (v[3:0] == 4'h0), c: c};
      end
      sm83_pkg::OP_DAA: begin
        res_o.acc   = daa_res;
        res_o.flags = '{z: (daa_res == 8'd0), n: flags_i.n, h: 1'b0,
                        c: (flags_i.n ? c : daa_hi)};
      end
      sm83_pkg::OP_CPL: begin
        res_o.acc     = ~acc_i;
        res_o.flags.n = 1'b1;
        res_o.flags.h = 1'b1;
      end
      sm83_pkg::OP_CCF: res_o.flags = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: ~c};
      sm83_pkg::OP_SCF: res_o.flags = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: 1'b1};
      sm83_pkg::OP_RLC: begin
        res_o.byte_res = {v[6:0], v[7]};
        res_o.msb_out  = v[7];
      end
      sm83_pkg::OP_RL: begin
        res_o.byte_res = {v[6:0], item_i.shift_in};
        res_o.msb_out  = v[7];
      end
      sm83_pkg::OP_RRC, sm83_pkg::OP_RR, sm83_pkg::OP_SRA, sm83_pkg::OP_SRL: begin
        priority case (sm83_pkg::op_e'(item_i.kind))
          sm83_pkg::OP_RRC: byte_r = {v[0], v[7:1]};
          sm83_pkg::OP_RR:  byte_r = {c, v[7:1]};
          sm83_pkg::OP_SRA: byte_r = {v[7], v[7:1]};
          default:          byte_r = {1'b0, v[7:1]};
        endcase
        res_o.byte_res = byte_r;
        res_o.flags    = '{z: (byte_r == 8'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      sm83_pkg::OP_SLA: begin
        byte_r         = {v[6:0], 1'b0};
        res_o.byte_res = byte_r;
        res_o.flags    = '{z: (byte_r == 8'd0), n: 1'b0, h: 1'b0, c: v[7]};
      end
      sm83_pkg::OP_BIT: res_o.flags = '{z: ~v[item_i.bit_index], n: 1'b0, h: 1'b1, c: c};
      sm83_pkg::OP_SET: res_o.byte_res = v | bit_mask;
      sm83_pkg::OP_RES: res_o.byte_res = v & ~bit_mask;
      default: begin
        // Selector codes past RES leave the accumulator and the flags as they are.
        res_o.acc = acc_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/sm83_alu.sv -----
// Top level of the SM83 ALU: input register, accumulator and flag state,
// result register and the handshake. Depends on sm83_pkg and sm83_exec.
`default_nettype none

// The SM83 ALU executes one operation per word and keeps the accumulator and
// the Z, N, H and C flags between words. It sustains one word per clock cycle
// while the consumer does not stall the result register. A word taken in sits
// in the input register, is executed by a single pass of combinational logic
// against the current accumulator and flags, and its result is loaded into the
// result register together with the new accumulator and flags as soon as the
// result register is empty or its word is being taken, so the word that follows
// directly sees the state left by the one before. When the result register is
// full and the consumer stalls, the word in the input register waits, and
// in_stall_o rises only then; while the input register can move on, a new word
// is taken in the same cycle. Every word yields exactly one result word
// carrying the accumulator, the flags, the 8-bit and 16-bit results and the
// old bit 7 of the left rotates; results that an operation does not produce
// read as zero. Reset clears the accumulator and the flags.

module sm83_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  kind_i,
  input  logic [15:0] operand_i,
  input  logic [15:0] base_word_i,
  input  logic [2:0]  bit_index_i,
  input  logic        shift_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  acc_out_o,
  output logic [3:0]  flags_out_o,
  output logic [7:0]  byte_result_o,
  output logic [15:0] word_result_o,
  output logic        msb_out_o
);

  sm83_pkg::item_t   item_q;
  logic              item_valid_q;
  sm83_pkg::result_t res_d;
  sm83_pkg::result_t res_q;
  logic              res_valid_q;
  logic [7:0]        acc_q;
  sm83_pkg::flags_t  flags_q;

  logic advance;
  logic accept;

  // The word in the input register executes when the result register is
  // empty or its word is being taken at this edge.
  assign advance    = item_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  sm83_exec u_exec (
    .item_i  (item_q),
    .acc_i   (acc_q),
    .flags_i (flags_q),
    .res_o   (res_d)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (accept) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{kind: kind_i, operand: operand_i, base_word: base_word_i,
                  bit_index: bit_index_i, shift_in: shift_in_i};
    end
  end

  // Architectural state moves with every executed word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      flags_q <= '0;
    end else if (advance) begin
      acc_q   <= res_d.acc;
      flags_q <= res_d.flags;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = res_valid_q;
  assign acc_out_o     = res_q.acc;
  assign flags_out_o   = res_q.flags;
  assign byte_result_o = res_q.byte_res;
  assign word_result_o = res_q.word_res;
  assign msb_out_o     = res_q.msb_out;

endmodule

`default_nettype wire
